// ----- src/mm_pkg.sv -----
// Package for the matrix multiplier: dimensions, operation and register codes,
// stream field widths, control structs and index helpers.
// No dependencies; imported by mm_mac and matrix_multiply_core.
package mm_pkg;

   localparam int MaxDim   = 8;
   localparam int DimCap   = (MaxDim < 8) ? MaxDim : 8;
   localparam int Depth    = MaxDim * MaxDim;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

   localparam int IdxW     = 3;
   localparam int DimW     = 4;
   localparam int ElemW    = 16;
   localparam int ProdW    = 2 * ElemW;
   localparam int AccW     = 40;

   localparam int OpW      = 2;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 48;
   localparam int CsrIdxW  = 3;

   localparam logic [OpW-1:0] OpWriteA  = 2'd0;
   localparam logic [OpW-1:0] OpWriteB  = 2'd1;
   localparam logic [OpW-1:0] OpCompute = 2'd2;

   localparam logic [CsrIdxW-1:0] RegARows = 3'd0;
   localparam logic [CsrIdxW-1:0] RegACols = 3'd1;
   localparam logic [CsrIdxW-1:0] RegBRows = 3'd2;
   localparam logic [CsrIdxW-1:0] RegBCols = 3'd3;

   typedef logic [IdxW-1:0]          idx_type;
   typedef logic [DimW-1:0]          dim_type;
   typedef logic [AddrW-1:0]         addr_type;
   typedef logic signed [ElemW-1:0]  elem_type;
   typedef logic signed [AccW-1:0]   acc_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   function automatic addr_type mm_addr(idx_type row, idx_type col);
      return addr_type'(row) * addr_type'(MaxDim) + addr_type'(col);
   endfunction

   function automatic logic mm_in_range(idx_type row, idx_type col);
      return ({2'b00, row} < 5'(MaxDim)) && ({2'b00, col} < 5'(MaxDim));
   endfunction

   function automatic dim_type mm_clamp(dim_type v);
      dim_type r;
      if (v == '0) begin
         r = dim_type'(1);
      end else if ({1'b0, v} > 5'(DimCap)) begin
         r = dim_type'(DimCap);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- src/mm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the element stores of the matrix multiplier.
module mm_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                           wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                           rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mm_mac.sv -----
// Shared multiply-accumulate unit: a registered 16x16 signed multiply followed
// by a 40-bit accumulator. Depends on mm_pkg.
module mm_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  mm_pkg::elem_type     a_q,
   input  mm_pkg::elem_type     b_q,
   input  mm_pkg::mac_ctl_type  ctl,
   output mm_pkg::acc_type      acc,
   output logic                 done
);
   import mm_pkg::*;

   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;
   mac_ctl_type             ctl_ff;
   acc_type                 acc_ff;
   acc_type                 acc_in;
   acc_type                 prod_ext;
   logic                    done_ff;
   logic                    done_in;

   assign prod_in  = a_q * b_q;
   assign prod_ext = {{(AccW-ProdW){prod_ff[ProdW-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (ctl_ff.valid) begin
         acc_in = ctl_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   assign done_in = ctl_ff.valid & ctl_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ----- src/matrix_multiply_core.sv -----
// Matrix multiplier top level: element stores, sequencer, shared MAC and result register.
// A compute with a_cols = n issues n reads through the single MAC for each product
// element, drains the MAC pipeline (RAM read, product and accumulator registers) and
// emits the element once the result slot is free; a dimension mismatch gives an error.
// Requests are refused while a compute runs. Reset clears the sequencer and the result
// valid flag and sets all dimensions to 1; the element stores stay undefined until written.
module matrix_multiply_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // row [2:0], col [5:3], value [21:6], zero [23:22]
   input  logic [mm_pkg::ReqDataW-1:0]  req_tdata,
   // operation [1:0]
   input  logic [mm_pkg::OpW-1:0]       req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_row [2:0], out_col [5:3], product [45:6], zero [47:46]
   output logic [mm_pkg::RspDataW-1:0]  rsp_tdata,
   // error [0]
   output logic                         rsp_tuser,
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mm_pkg::DimW-1:0]      csr_data
);
   import mm_pkg::*;

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StIssue = 3'd1;
   localparam logic [2:0] StDrain = 3'd2;
   localparam logic [2:0] StEmit  = 3'd3;
   localparam logic [2:0] StError = 3'd4;

   logic [2:0]   state_ff, state_in;
   idx_type      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   dim_type      a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   mac_ctl_type  ctl_ff, ctl_in;

   logic         rsp_valid_ff, rsp_valid_in;
   idx_type      out_row_ff, out_col_ff;
   acc_type      product_ff;
   logic         error_ff, last_ff;

   logic         req_fire, slot_free, load_elem, load_err;
   logic         last_k, last_j, last_i;
   idx_type      in_row, in_col;
   elem_type     in_value, a_q, b_q;
   addr_type     wr_addr, a_rd_addr, b_rd_addr;
   logic         wr_ok, wr_a, wr_b;
   acc_type      mac_acc;
   logic         mac_done;

   assign in_row   = req_tdata[2:0];
   assign in_col   = req_tdata[5:3];
   assign in_value = req_tdata[21:6];

   assign req_tready = (state_ff == StIdle);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign wr_addr = mm_addr(in_row, in_col);
   assign wr_ok   = req_fire & mm_in_range(in_row, in_col);
   assign wr_a    = wr_ok & (req_tuser == OpWriteA);
   assign wr_b    = wr_ok & (req_tuser == OpWriteB);

   assign a_rd_addr = mm_addr(i_ff, k_ff);
   assign b_rd_addr = mm_addr(k_ff, j_ff);

   assign last_k = (({1'b0, k_ff} + 4'd1) == a_cols_ff);
   assign last_j = (({1'b0, j_ff} + 4'd1) == b_cols_ff);
   assign last_i = (({1'b0, i_ff} + 4'd1) == a_rows_ff);

   assign slot_free = ~rsp_valid_ff | rsp_tready;
   assign load_elem = (state_ff == StEmit) & slot_free;
   assign load_err  = (state_ff == StError) & slot_free;

   mm_ram #(.Width(ElemW), .Depth(Depth)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (in_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_q)
   );

   mm_ram #(.Width(ElemW), .Depth(Depth)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (in_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_q)
   );

   mm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .a_q   (a_q),
      .b_q   (b_q),
      .ctl   (ctl_ff),
      .acc   (mac_acc),
      .done  (mac_done)
   );

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      ctl_in   = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_fire && req_tuser == OpCompute) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               state_in = (a_cols_ff == b_rows_ff) ? StIssue : StError;
            end
         end
         StIssue: begin
            ctl_in.valid = 1'b1;
            ctl_in.first = (k_ff == '0);
            ctl_in.last  = last_k;
            if (last_k) begin
               state_in = StDrain;
            end else begin
               k_in = k_ff + idx_type'(1);
            end
         end
         StDrain: begin
            if (mac_done) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (slot_free) begin
               k_in = '0;
               if (last_j) begin
                  j_in = '0;
                  i_in = i_ff + idx_type'(1);
               end else begin
                  j_in = j_ff + idx_type'(1);
               end
               state_in = (last_i && last_j) ? StIdle : StIssue;
            end
         end
         StError: begin
            if (slot_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (load_elem || load_err) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         a_rows_ff    <= dim_type'(1);
         a_cols_ff    <= dim_type'(1);
         b_rows_ff    <= dim_type'(1);
         b_cols_ff    <= dim_type'(1);
      end else begin
         state_ff     <= state_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               RegARows: a_rows_ff <= mm_clamp(csr_data);
               RegACols: a_cols_ff <= mm_clamp(csr_data);
               RegBRows: b_rows_ff <= mm_clamp(csr_data);
               RegBCols: b_cols_ff <= mm_clamp(csr_data);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (load_elem) begin
         out_row_ff <= i_ff;
         out_col_ff <= j_ff;
         product_ff <= mac_acc;
         error_ff   <= 1'b0;
         last_ff    <= last_i & last_j;
      end else if (load_err) begin
         out_row_ff <= '0;
         out_col_ff <= '0;
         product_ff <= '0;
         error_ff   <= 1'b1;
         last_ff    <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, product_ff, out_col_ff, out_row_ff};
   assign rsp_tuser  = error_ff;
   assign rsp_tlast  = last_ff;

endmodule
